[design/fat_pkg.sv]
// ----------------------------------------------------------------------------
// fat_pkg: shared types and constants of the fat-ray voxel occlusion block
// Holds payload types, operation and result codes, register indexes and the
// default grid dimensions.
// ----------------------------------------------------------------------------
package fat_pkg;

   // default grid dimensions in voxels
   localparam int GRID_X_DEF = 64;
   localparam int GRID_Y_DEF = 64;
   localparam int GRID_Z_DEF = 32;

   // field widths
   localparam int COORD_W    = 24;
   localparam int VS_W       = 16;
   localparam int ORG_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // command queue between front and back
   localparam int FIFO_DEPTH = 4;

   typedef logic [1:0]                 func_type;
   typedef logic signed [COORD_W-1:0]  coord_type;
   typedef logic [1:0]                 vis_type;
   typedef logic [CSR_IDX_W-1:0]       csr_idx_type;
   typedef logic [CSR_DATA_W-1:0]      csr_data_type;
   typedef logic [1:0]                 op_type;

   // request function codes
   localparam func_type FUNC_MARK  = 2'd0;
   localparam func_type FUNC_QUERY = 2'd1;
   localparam func_type FUNC_CLEAR = 2'd2;

   // classified operations
   localparam op_type OP_MARK  = 2'd0;
   localparam op_type OP_QUERY = 2'd1;
   localparam op_type OP_POP   = 2'd2;
   localparam op_type OP_CLEAR = 2'd3;

   // result codes
   localparam vis_type VIS_VISIBLE   = 2'd0;
   localparam vis_type VIS_POPULATED = 2'd1;
   localparam vis_type VIS_OCCLUDED  = 2'd2;

   // register indexes
   localparam csr_idx_type REG_VOXEL_SIZE = 3'd0;
   localparam csr_idx_type REG_SCAN_X     = 3'd1;
   localparam csr_idx_type REG_SCAN_Y     = 3'd2;
   localparam csr_idx_type REG_SCAN_Z     = 3'd3;
   localparam csr_idx_type REG_ORIGIN_X   = 3'd4;
   localparam csr_idx_type REG_ORIGIN_Y   = 3'd5;
   localparam csr_idx_type REG_ORIGIN_Z   = 3'd6;

   localparam logic [VS_W-1:0] VOXEL_SIZE_RST = 16'd10;

   typedef struct packed {
      op_type    op;
      coord_type px;
      coord_type py;
      coord_type pz;
   } cmd_type;

   // front to back: head of the command queue
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_type;

   // back to front: status and dequeue
   typedef struct packed {
      logic map_ready;
      logic pop;
   } back_stat_type;

endpackage

[design/fat_if.sv]
// ----------------------------------------------------------------------------
// fat_if: channel interfaces of the fat-ray voxel occlusion block
// Request, response and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fat_req_if;
   logic               valid;
   logic               ready;
   fat_pkg::func_type  func;
   fat_pkg::coord_type point_x;
   fat_pkg::coord_type point_y;
   fat_pkg::coord_type point_z;
   logic               populated;

   modport source (output valid, func, point_x, point_y, point_z, populated,
                   input ready);
   modport sink   (input valid, func, point_x, point_y, point_z, populated,
                   output ready);
endinterface

interface fat_rsp_if;
   logic             valid;
   logic             ready;
   fat_pkg::vis_type visibility;

   modport source (output valid, visibility, input ready);
   modport sink   (input valid, visibility, output ready);
endinterface

interface fat_csr_if;
   logic                  valid;
   logic                  ready;
   fat_pkg::csr_idx_type  index;
   fat_pkg::csr_data_type data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[design/fat_ray_voxel_occlusion_top.sv]
// A mark runs three 24-bit floor divisions at one quotient bit per cycle,
// then a row read and write; a query runs six floor and six 48-bit divisions
// of setup, then its DDA steps.
// Throughput: one command at a time in the back end behind a four-entry queue;
// a clear sweeps GRID_X*GRID_Y map rows.
// Reset returns the registers to their reset values and runs the same sweep with req_ch.ready low.
// ----------------------------------------------------------------------------
// fat_ray_voxel_occlusion_top: fat-ray voxel occlusion block
// Intake front, command queue and DDA back end over a one-bit obstacle map.
// ----------------------------------------------------------------------------
module fat_ray_voxel_occlusion_top #(
   parameter int GRID_X = fat_pkg::GRID_X_DEF,
   parameter int GRID_Y = fat_pkg::GRID_Y_DEF,
   parameter int GRID_Z = fat_pkg::GRID_Z_DEF
) (
   input  logic      clock,
   input  logic      reset,
   fat_req_if.sink   req_ch,
   fat_rsp_if.source rsp_ch,
   fat_csr_if.sink   csr_ch
);
   import fat_pkg::*;

   queue_type     q;
   back_stat_type stat;

   fat_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .stat  (stat),
      .q     (q)
   );

   fat_back #(
      .GRID_X (GRID_X),
      .GRID_Y (GRID_Y),
      .GRID_Z (GRID_Z)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .q     (q),
      .stat  (stat),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // hold off requests while the map is swept after reset
   a_reset_sweep: assert property (@(posedge clock) reset |=> !req_ch.ready)
      else $error("request accepted during the reset clearing sweep");

   // dequeue only a present command
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      stat.pop |-> q.valid)
      else $error("command dequeued from an empty queue");

   // only defined result codes leave the block
   a_vis_code: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.visibility == VIS_VISIBLE ||
                        rsp_ch.visibility == VIS_POPULATED ||
                        rsp_ch.visibility == VIS_OCCLUDED))
      else $error("undefined visibility code on the response channel");
endmodule

[design/fat_div.sv]
// ----------------------------------------------------------------------------
// fat_div: shared restoring divider
// Produces one quotient bit per cycle for a left-aligned 48-bit dividend and
// a 25-bit divisor; the caller picks the number of quotient bits.
// ----------------------------------------------------------------------------
module fat_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [47:0] dividend,
   input  logic [24:0] divisor,
   input  logic [5:0]  iters,
   output logic        done,
   output logic [47:0] quotient,
   output logic [24:0] remainder
);
   logic [24:0] rem_ff, rem_in;
   logic [47:0] dvd_ff, dvd_in;
   logic [47:0] quo_ff, quo_in;
   logic [24:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [25:0] part;
   logic [26:0] diff;
   logic        ge;

   // trial subtraction of one bit
   always_comb begin
      part   = {rem_ff, dvd_ff[47]};
      diff   = {1'b0, part} - {2'b00, dvs_ff};
      ge     = !diff[26];
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         dvd_in = dividend;
         quo_in = '0;
         dvs_in = divisor;
         cnt_in = iters;
      end else if (cnt_ff != 6'd0) begin
         rem_in  = ge ? diff[24:0] : part[24:0];
         dvd_in  = {dvd_ff[46:0], 1'b0};
         quo_in  = {quo_ff[46:0], ge};
         cnt_in  = cnt_ff - 6'd1;
         done_in = (cnt_ff == 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

[design/fat_front.sv]
// ----------------------------------------------------------------------------
// fat_front: request intake and classification
// Decodes each request into an operation, drops unused codes and holds the
// commands in a short queue for the back end.
// ----------------------------------------------------------------------------
module fat_front (
   input  logic                   clock,
   input  logic                   reset,
   fat_req_if.sink                req,
   input  fat_pkg::back_stat_type stat,
   output fat_pkg::queue_type     q
);
   import fat_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);

   cmd_type            fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;
   logic               take;
   logic               push;
   cmd_type            cmd;

   // accept while the map is usable and the queue has room
   assign req.ready = stat.map_ready && (count_ff < (PTR_W+1)'(FIFO_DEPTH));
   assign take      = req.valid && req.ready;

   // classify the transaction
   always_comb begin
      cmd.px = req.point_x;
      cmd.py = req.point_y;
      cmd.pz = req.point_z;
      cmd.op = OP_MARK;
      push   = take;
      unique case (req.func)
         FUNC_MARK:  cmd.op = OP_MARK;
         FUNC_QUERY: cmd.op = req.populated ? OP_POP : OP_QUERY;
         FUNC_CLEAR: cmd.op = OP_CLEAR;
         default:    push   = 1'b0;
      endcase
   end

   // advance pointers
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = stat.pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(stat.pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign q.valid = (count_ff != '0);
   assign q.cmd   = fifo_ff[rd_ptr_ff];
endmodule

[design/fat_back.sv]
// ----------------------------------------------------------------------------
// fat_back: command execution
// Holds the registers and the obstacle map (one row of z bits per x,y pair),
// marks and clears the map and walks query rays with a DDA sequencer.
// ----------------------------------------------------------------------------
module fat_back #(
   parameter int GRID_X = fat_pkg::GRID_X_DEF,
   parameter int GRID_Y = fat_pkg::GRID_Y_DEF,
   parameter int GRID_Z = fat_pkg::GRID_Z_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  fat_pkg::queue_type     q,
   output fat_pkg::back_stat_type stat,
   fat_rsp_if.source              rsp,
   fat_csr_if.sink                csr
);
   import fat_pkg::*;

   localparam int ROWS   = GRID_X * GRID_Y;
   localparam int ROW_W  = $clog2(ROWS);
   localparam int Z_W    = $clog2(GRID_Z);
   localparam int D_W    = COORD_W + 1;
   localparam int IDX_W  = COORD_W + 2;
   localparam int AD_W   = COORD_W + 1;
   localparam int LOC_W  = IDX_W + 1;
   localparam int CNT_W  = IDX_W + 1;
   localparam int T_W    = 64;
   localparam int PROBES = 5;

   localparam logic [3:0] ST_CLEAR    = 4'd0;
   localparam logic [3:0] ST_IDLE     = 4'd1;
   localparam logic [3:0] ST_DIV_GO   = 4'd2;
   localparam logic [3:0] ST_DIV_WAIT = 4'd3;
   localparam logic [3:0] ST_SETUP    = 4'd4;
   localparam logic [3:0] ST_MARK_RD  = 4'd5;
   localparam logic [3:0] ST_MARK_WR  = 4'd6;
   localparam logic [3:0] ST_WALK     = 4'd7;
   localparam logic [3:0] ST_END      = 4'd8;
   localparam logic [3:0] ST_PROBE    = 4'd9;
   localparam logic [3:0] ST_EMIT     = 4'd10;

   // division jobs: point floors, scanner floors, then delta/max per axis
   localparam logic [3:0] JOB_PT_LAST   = 4'd2;
   localparam logic [3:0] JOB_SCAN_0    = 4'd3;
   localparam logic [3:0] JOB_SCAN_LAST = 4'd5;
   localparam logic [3:0] JOB_T_0       = 4'd6;
   localparam logic [3:0] JOB_T_LAST    = 4'd11;

   // ---------------- registers ----------------
   logic [VS_W-1:0]            vs_ff;
   coord_type                  scan_ff [3];
   logic signed [ORG_W-1:0]    org_ff  [3];

   logic [3:0]                 state_ff, state_in;
   op_type                     op_ff, op_in;
   coord_type                  pt_ff   [3];
   coord_type                  pt_in   [3];
   logic [3:0]                 job_ff, job_in;
   logic signed [IDX_W-1:0]    pos_ff  [3];
   logic signed [IDX_W-1:0]    pos_in  [3];
   logic signed [IDX_W-1:0]    end_ff  [3];
   logic signed [IDX_W-1:0]    end_in  [3];
   logic [VS_W-1:0]            rf_ff   [3];
   logic [VS_W-1:0]            rf_in   [3];
   logic [AD_W-1:0]            ad_ff   [3];
   logic [AD_W-1:0]            ad_in   [3];
   logic                       neg_ff  [3];
   logic                       neg_in  [3];
   logic [T_W-1:0]             tm_ff   [3];
   logic [T_W-1:0]             tm_in   [3];
   logic [T_W-1:0]             td_ff   [3];
   logic [T_W-1:0]             td_in   [3];
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [1:0]                 axis_ff, axis_in;
   logic [2:0]                 probe_ff, probe_in;
   logic                       chk_ok_ff, chk_ok_in;
   logic [Z_W-1:0]             lz_ff, lz_in;
   logic [ROW_W-1:0]           row_ff, row_in;
   logic [ROW_W-1:0]           clr_ff, clr_in;
   vis_type                    res_ff, res_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   vis_type                    rsp_vis_ff, rsp_vis_in;

   logic [GRID_Z-1:0]          map_mem [ROWS];
   logic [GRID_Z-1:0]          rd_data_ff;

   // ---------------- combinational signals ----------------
   logic [VS_W-1:0]            vs_eff;
   logic [1:0]                 jax;
   logic                       job_scan;
   logic                       job_t;
   coord_type                  fl_val;
   logic                       fl_neg;
   logic [COORD_W-1:0]         fl_mag;
   logic [VS_W-1:0]            rr;
   logic                       rnz;
   logic [IDX_W-1:0]           q0_ext;
   logic signed [IDX_W-1:0]    fl_idx;
   logic [VS_W-1:0]            fl_rf;
   logic [VS_W-1:0]            n_sel;
   logic [AD_W-1:0]            ad_sel;
   logic [T_W-1:0]             t_res;
   logic                       div_start;
   logic [47:0]                div_dvd;
   logic [24:0]                div_dvs;
   logic [5:0]                 div_iters;
   logic                       div_done;
   logic [47:0]                div_quo;
   logic [24:0]                div_rem;

   logic signed [D_W-1:0]      dv   [3];
   logic                       dneg [3];
   logic [AD_W-1:0]            dabs [3];
   logic signed [IDX_W-1:0]    ed   [3];
   logic [AD_W-1:0]            eabs [3];
   logic                       same_vox;
   logic [CNT_W-1:0]           nsteps;

   logic                       lt_xy, lt_xz, lt_yz;
   logic [1:0]                 sel;
   logic [T_W:0]               tsum [3];
   logic [T_W-1:0]             tnext [3];

   logic [1:0]                 n1, n2;
   logic signed [1:0]          off  [3];
   logic signed [IDX_W-1:0]    crd  [3];
   logic signed [LOC_W-1:0]    loc  [3];
   logic                       in_grid;
   logic [ROW_W-1:0]           row_calc;
   logic [Z_W-1:0]             lz_calc;
   logic                       at_end;
   logic                       emit_go;
   logic                       wr_en;
   logic [ROW_W-1:0]           wr_addr;
   logic [GRID_Z-1:0]          wr_data;
   logic                       pop;

   // ---------------- register file ----------------
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vs_ff <= VOXEL_SIZE_RST;
         for (int a = 0; a < 3; a++) begin
            scan_ff[a] <= '0;
            org_ff[a]  <= '0;
         end
      end else if (csr.valid) begin
         unique case (csr.index)
            REG_VOXEL_SIZE: vs_ff      <= csr.data[VS_W-1:0];
            REG_SCAN_X:     scan_ff[0] <= csr.data;
            REG_SCAN_Y:     scan_ff[1] <= csr.data;
            REG_SCAN_Z:     scan_ff[2] <= csr.data;
            REG_ORIGIN_X:   org_ff[0]  <= csr.data[ORG_W-1:0];
            REG_ORIGIN_Y:   org_ff[1]  <= csr.data[ORG_W-1:0];
            REG_ORIGIN_Z:   org_ff[2]  <= csr.data[ORG_W-1:0];
            default: ;
         endcase
      end
   end

   assign vs_eff = (vs_ff == '0) ? VS_W'(1) : vs_ff;

   // ---------------- divider operands and results ----------------
   always_comb begin
      unique case (job_ff)
         4'd0, 4'd3, 4'd6, 4'd7:   jax = 2'd0;
         4'd1, 4'd4, 4'd8, 4'd9:   jax = 2'd1;
         4'd2, 4'd5, 4'd10, 4'd11: jax = 2'd2;
         default:                  jax = 2'd0;
      endcase
      job_scan = (job_ff >= JOB_SCAN_0) && (job_ff <= JOB_SCAN_LAST);
      job_t    = (job_ff >= JOB_T_0);

      unique case (jax)
         2'd0:    fl_val = job_scan ? scan_ff[0] : pt_ff[0];
         2'd1:    fl_val = job_scan ? scan_ff[1] : pt_ff[1];
         default: fl_val = job_scan ? scan_ff[2] : pt_ff[2];
      endcase
      unique case (jax)
         2'd0:    begin n_sel = neg_ff[0] ? rf_ff[0] : vs_eff - rf_ff[0]; ad_sel = ad_ff[0]; end
         2'd1:    begin n_sel = neg_ff[1] ? rf_ff[1] : vs_eff - rf_ff[1]; ad_sel = ad_ff[1]; end
         default: begin n_sel = neg_ff[2] ? rf_ff[2] : vs_eff - rf_ff[2]; ad_sel = ad_ff[2]; end
      endcase

      fl_neg = fl_val[COORD_W-1];
      fl_mag = fl_neg ? COORD_W'(-fl_val) : COORD_W'(fl_val);

      // floor the signed quotient and keep the distance to the voxel floor
      rr     = div_rem[VS_W-1:0];
      rnz    = (rr != '0);
      q0_ext = IDX_W'(div_quo[COORD_W-1:0]);
      fl_idx = fl_neg ? $signed(IDX_W'(0) - q0_ext - IDX_W'(rnz)) : $signed(q0_ext);
      fl_rf  = (fl_neg && rnz) ? vs_eff - rr : rr;

      // an axis without motion saturates
      t_res  = (ad_sel == '0) ? {T_W{1'b1}} : T_W'(div_quo);

      if (job_t) begin
         div_dvd   = job_ff[0] ? {n_sel, 32'd0} : {vs_eff, 32'd0};
         div_dvs   = ad_sel;
         div_iters = 6'd48;
      end else begin
         div_dvd   = {fl_mag, 24'd0};
         div_dvs   = 25'(vs_eff);
         div_iters = 6'd24;
      end
   end

   assign div_start = (state_ff == ST_DIV_GO);

   fat_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .iters     (div_iters),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // ---------------- ray setup ----------------
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         dv[a]   = D_W'(pt_ff[a]) - D_W'(scan_ff[a]);
         dneg[a] = dv[a][D_W-1];
         dabs[a] = dneg[a] ? AD_W'(-dv[a]) : AD_W'(dv[a]);
         ed[a]   = end_ff[a] - pos_ff[a];
         eabs[a] = ed[a][IDX_W-1] ? AD_W'(-ed[a]) : AD_W'(ed[a]);
      end
      same_vox = (pos_ff[0] == end_ff[0]) && (pos_ff[1] == end_ff[1]) &&
                 (pos_ff[2] == end_ff[2]);
      nsteps   = CNT_W'(eabs[0]) + CNT_W'(eabs[1]) + CNT_W'(eabs[2]) + CNT_W'(2);
   end

   // ---------------- step selection ----------------
   always_comb begin
      lt_xy = tm_ff[0] < tm_ff[1];
      lt_xz = tm_ff[0] < tm_ff[2];
      lt_yz = tm_ff[1] < tm_ff[2];
      priority if (lt_xy && lt_xz) sel = 2'd0;
      else if (!lt_xy && lt_yz)    sel = 2'd1;
      else                         sel = 2'd2;
      for (int a = 0; a < 3; a++) begin
         tsum[a]  = {1'b0, tm_ff[a]} + {1'b0, td_ff[a]};
         tnext[a] = tsum[a][T_W] ? {T_W{1'b1}} : tsum[a][T_W-1:0];
      end
   end

   // ---------------- probe addressing ----------------
   always_comb begin
      unique case (axis_ff)
         2'd0:    begin n1 = 2'd1; n2 = 2'd2; end
         2'd1:    begin n1 = 2'd0; n2 = 2'd2; end
         default: begin n1 = 2'd0; n2 = 2'd1; end
      endcase
      for (int a = 0; a < 3; a++) begin
         off[a] = 2'sd0;
         if ((probe_ff == 3'd1 && 2'(a) == n1) || (probe_ff == 3'd3 && 2'(a) == n2)) begin
            off[a] = 2'sd1;
         end
         if ((probe_ff == 3'd2 && 2'(a) == n1) || (probe_ff == 3'd4 && 2'(a) == n2)) begin
            off[a] = -2'sd1;
         end
         crd[a] = (state_ff == ST_MARK_RD) ? end_ff[a] : pos_ff[a] + IDX_W'(off[a]);
         loc[a] = LOC_W'(crd[a]) - LOC_W'(org_ff[a]);
      end
      in_grid  = !loc[0][LOC_W-1] && (loc[0] < LOC_W'(GRID_X)) &&
                 !loc[1][LOC_W-1] && (loc[1] < LOC_W'(GRID_Y)) &&
                 !loc[2][LOC_W-1] && (loc[2] < LOC_W'(GRID_Z));
      row_calc = ROW_W'(ROW_W'(loc[0]) * ROW_W'(GRID_Y)) + ROW_W'(loc[1]);
      lz_calc  = Z_W'(loc[2]);
      at_end   = same_vox;
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      job_in    = job_ff;
      cnt_in    = cnt_ff;
      axis_in   = axis_ff;
      probe_in  = probe_ff;
      chk_ok_in = chk_ok_ff;
      lz_in     = lz_ff;
      row_in    = row_ff;
      clr_in    = clr_ff;
      res_in    = res_ff;
      for (int a = 0; a < 3; a++) begin
         pt_in[a]  = pt_ff[a];
         pos_in[a] = pos_ff[a];
         end_in[a] = end_ff[a];
         rf_in[a]  = rf_ff[a];
         ad_in[a]  = ad_ff[a];
         neg_in[a] = neg_ff[a];
         tm_in[a]  = tm_ff[a];
         td_in[a]  = td_ff[a];
      end
      pop     = 1'b0;
      wr_en   = 1'b0;
      wr_addr = clr_ff;
      wr_data = '0;
      emit_go = 1'b0;

      unique case (state_ff)
         // sweep the map to zero, one row a cycle
         ST_CLEAR: begin
            wr_en = 1'b1;
            if (clr_ff == ROW_W'(ROWS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + ROW_W'(1);
            end
         end
         // take the next command
         ST_IDLE: begin
            if (q.valid) begin
               pop      = 1'b1;
               op_in    = q.cmd.op;
               pt_in[0] = q.cmd.px;
               pt_in[1] = q.cmd.py;
               pt_in[2] = q.cmd.pz;
               job_in   = '0;
               unique case (q.cmd.op)
                  OP_MARK, OP_QUERY: state_in = ST_DIV_GO;
                  OP_POP: begin
                     res_in   = VIS_POPULATED;
                     state_in = ST_EMIT;
                  end
                  default: begin
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
               endcase
            end
         end
         ST_DIV_GO: state_in = ST_DIV_WAIT;
         // store the finished division
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_DIV_GO;
               job_in   = job_ff + 4'd1;
               if (job_t) begin
                  if (job_ff[0]) tm_in[jax] = t_res;
                  else           td_in[jax] = t_res;
               end else if (job_scan) begin
                  pos_in[jax] = fl_idx;
                  rf_in[jax]  = fl_rf;
               end else begin
                  end_in[jax] = fl_idx;
               end
               if (job_ff == JOB_PT_LAST && op_ff == OP_MARK) state_in = ST_MARK_RD;
               if (job_ff == JOB_SCAN_LAST)                   state_in = ST_SETUP;
               if (job_ff == JOB_T_LAST)                      state_in = ST_WALK;
            end
         end
         // direction, distances and step budget
         ST_SETUP: begin
            for (int a = 0; a < 3; a++) begin
               neg_in[a] = dneg[a];
               ad_in[a]  = dabs[a];
            end
            cnt_in = nsteps;
            job_in = JOB_T_0;
            if (same_vox) begin
               res_in   = VIS_VISIBLE;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_DIV_GO;
            end
         end
         ST_MARK_RD: begin
            row_in = row_calc;
            lz_in  = lz_calc;
            state_in = in_grid ? ST_MARK_WR : ST_IDLE;
         end
         // set the bit in the row read last cycle
         ST_MARK_WR: begin
            wr_en    = 1'b1;
            wr_addr  = row_ff;
            wr_data  = rd_data_ff | (GRID_Z'(1) << lz_ff);
            state_in = ST_IDLE;
         end
         // advance along the axis with the nearest boundary
         ST_WALK: begin
            if (cnt_ff == '0) begin
               res_in   = VIS_VISIBLE;
               state_in = ST_EMIT;
            end else begin
               for (int a = 0; a < 3; a++) begin
                  if (sel == 2'(a)) begin
                     pos_in[a] = neg_ff[a] ? pos_ff[a] - IDX_W'(1) : pos_ff[a] + IDX_W'(1);
                     tm_in[a]  = tnext[a];
                  end
               end
               axis_in  = sel;
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = ST_END;
            end
         end
         ST_END: begin
            probe_in  = '0;
            chk_ok_in = 1'b0;
            if (at_end) begin
               res_in   = VIS_VISIBLE;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_PROBE;
            end
         end
         // read the voxel and its four neighbors, checking each read in the next cycle
         ST_PROBE: begin
            if (chk_ok_ff && rd_data_ff[lz_ff]) begin
               res_in   = VIS_OCCLUDED;
               state_in = ST_EMIT;
            end else if (probe_ff == 3'(PROBES)) begin
               state_in = ST_WALK;
            end else begin
               chk_ok_in = in_grid;
               lz_in     = lz_calc;
               probe_in  = probe_ff + 3'd1;
            end
         end
         // hand the result to the output register
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               emit_go  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_vis_in   = rsp_vis_ff;
      if (emit_go) begin
         rsp_valid_in = 1'b1;
         rsp_vis_in   = res_ff;
      end
   end

   // ---------------- map memory ----------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= map_mem[row_calc];
   end

   // ---------------- state registers ----------------
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      job_ff     <= job_in;
      cnt_ff     <= cnt_in;
      axis_ff    <= axis_in;
      probe_ff   <= probe_in;
      lz_ff      <= lz_in;
      row_ff     <= row_in;
      res_ff     <= res_in;
      rsp_vis_ff <= rsp_vis_in;
      for (int a = 0; a < 3; a++) begin
         pt_ff[a]  <= pt_in[a];
         pos_ff[a] <= pos_in[a];
         end_ff[a] <= end_in[a];
         rf_ff[a]  <= rf_in[a];
         ad_ff[a]  <= ad_in[a];
         neg_ff[a] <= neg_in[a];
         tm_ff[a]  <= tm_in[a];
         td_ff[a]  <= td_in[a];
      end
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         chk_ok_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         chk_ok_ff    <= chk_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign stat.map_ready = (state_ff != ST_CLEAR);
   assign stat.pop       = pop;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.visibility = rsp_vis_ff;
endmodule

[dv/fat_tb_if.sv]
// ----------------------------------------------------------------------------
// fat_tb_if: note on channel interfaces used by the testbench
// The testbench reuses the block's own channel interfaces from the design
// folder; this file holds the shared testbench constants.
// ----------------------------------------------------------------------------
package fat_tb_pkg;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_HALF  = 5;
   localparam int RST_CYC   = 9;
   localparam int IDLE_LIM  = 200000;
   // five queued clears back to back, with margin
   localparam int DRAIN_CYC = 21000;
endpackage

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: fat-ray voxel occlusion block check
// Drives marks, clears and occlusion queries under several register settings
// and idle patterns, predicts each visibility with an in-bench DDA walk over a
// private copy of the obstacle map and compares every response in order.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import fat_pkg::*;

   localparam int GX = GRID_X_DEF;
   localparam int GY = GRID_Y_DEF;
   localparam int GZ = GRID_Z_DEF;
   localparam logic [63:0] T_ALL = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fat_req_if req_ch ();
   fat_rsp_if rsp_ch ();
   fat_csr_if csr_ch ();

   fat_ray_voxel_occlusion_top u_top (
      .clock (clock), .reset (reset),
      .req_ch (req_ch.sink), .rsp_ch (rsp_ch.source), .csr_ch (csr_ch.sink)
   );

   always #(fat_tb_pkg::CLK_HALF) clock = ~clock;

   // predictor copy of the block state
   bit          occ_map [GX*GY*GZ];
   logic [15:0] p_vs;
   logic signed [23:0] p_scan [3];
   logic signed [15:0] p_org [3];

   vis_type     vis_expected [$];
   int          err_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          quiet_cycles = 0;

   // directed table: func, point, populated, typed-in result (-1 = predict)
   typedef struct {
      func_type func;
      int       px, py, pz;
      bit       pop;
      int       fixed_vis;
   } stim_row;

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      err_count++;
   endtask

   function automatic longint fdiv(input longint a, input longint d);
      longint q;
      q = a / d;
      if ((a % d) != 0 && a < 0) q--;
      return q;
   endfunction

   function automatic bit map_in(input longint x, input longint y, input longint z,
                                 output int pos);
      longint lx, ly, lz;
      lx = x - p_org[0];
      ly = y - p_org[1];
      lz = z - p_org[2];
      pos = 0;
      if (lx < 0 || lx >= GX || ly < 0 || ly >= GY || lz < 0 || lz >= GZ)
         return 0;
      pos = int'((lx * GY + ly) * GZ + lz);
      return 1;
   endfunction

   function automatic bit occupied(input longint x, input longint y, input longint z);
      int pos;
      if (!map_in(x, y, z, pos)) return 0;
      return occ_map[pos];
   endfunction

   function automatic longint cur_vs();
      return (p_vs == 0) ? 1 : longint'(p_vs);
   endfunction

   function automatic logic [63:0] t_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? T_ALL : s[63:0];
   endfunction

   // per-axis ray setup: first crossing and crossing spacing
   function automatic void ray_axis(input longint s, input longint e, input longint idx,
                                    input longint vs, output logic [63:0] tm,
                                    output logic [63:0] td, output longint stp);
      longint d, n, ad;
      d = e - s;
      stp = (d >= 0) ? 1 : -1;
      tm = T_ALL;
      td = T_ALL;
      if (d != 0) begin
         ad = (d > 0) ? d : -d;
         n = (d > 0) ? (idx + 1) * vs - s : s - idx * vs;
         if (n < 0) n = 0;
         td = (64'(vs) << 32) / 64'(ad);
         tm = (64'(n) << 32) / 64'(ad);
      end
   endfunction

   // walk the ray from scanner voxel to target voxel
   function automatic vis_type walk_ray(input longint px, input longint py,
                                        input longint pz);
      longint vs, c [3], e [3], st [3], nsteps, ad;
      logic [63:0] tm [3], td [3];
      int ax;
      vs = cur_vs();
      for (int a = 0; a < 3; a++) c[a] = fdiv(p_scan[a], vs);
      e[0] = fdiv(px, vs); e[1] = fdiv(py, vs); e[2] = fdiv(pz, vs);
      if (c[0] == e[0] && c[1] == e[1] && c[2] == e[2]) return VIS_VISIBLE;
      ray_axis(p_scan[0], px, c[0], vs, tm[0], td[0], st[0]);
      ray_axis(p_scan[1], py, c[1], vs, tm[1], td[1], st[1]);
      ray_axis(p_scan[2], pz, c[2], vs, tm[2], td[2], st[2]);
      nsteps = 2;
      for (int a = 0; a < 3; a++) begin
         ad = e[a] - c[a];
         nsteps += (ad < 0) ? -ad : ad;
      end
      for (longint k = 0; k < nsteps; k++) begin
         if (tm[0] < tm[1] && tm[0] < tm[2]) ax = 0;
         else if (tm[0] >= tm[1] && tm[1] < tm[2]) ax = 1;
         else ax = 2;
         c[ax] += st[ax];
         tm[ax] = t_add(tm[ax], td[ax]);
         if (c[0] == e[0] && c[1] == e[1] && c[2] == e[2]) return VIS_VISIBLE;
         if (occupied(c[0], c[1], c[2])) return VIS_OCCLUDED;
         if (ax != 0 && (occupied(c[0] + 1, c[1], c[2]) ||
                         occupied(c[0] - 1, c[1], c[2]))) return VIS_OCCLUDED;
         if (ax != 1 && (occupied(c[0], c[1] + 1, c[2]) ||
                         occupied(c[0], c[1] - 1, c[2]))) return VIS_OCCLUDED;
         if (ax != 2 && (occupied(c[0], c[1], c[2] + 1) ||
                         occupied(c[0], c[1], c[2] - 1))) return VIS_OCCLUDED;
      end
      return VIS_VISIBLE;
   endfunction

   // update the predictor for one accepted transaction
   task automatic predict_item(input func_type f, input longint px, input longint py,
                               input longint pz, input bit pop, input int fixed_vis);
      int pos;
      longint vs;
      vis_type v;
      vs = cur_vs();
      case (f)
         FUNC_MARK: begin
            if (map_in(fdiv(px, vs), fdiv(py, vs), fdiv(pz, vs), pos)) occ_map[pos] = 1;
         end
         FUNC_CLEAR: begin
            foreach (occ_map[i]) occ_map[i] = 0;
         end
         FUNC_QUERY: begin
            v = pop ? VIS_POPULATED : walk_ray(px, py, pz);
            if (fixed_vis >= 0 && int'(v) != fixed_vis)
               report("directed row vs predictor", v, fixed_vis);
            vis_expected.push_back((fixed_vis >= 0) ? vis_type'(fixed_vis) : v);
         end
         default: ;
      endcase
   endtask

   // send one transaction, honoring the idle pattern
   task automatic send_item(input func_type f, input int px, input int py,
                            input int pz, input bit pop, input int fixed_vis);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.func      <= f;
      req_ch.point_x   <= px[23:0];
      req_ch.point_y   <= py[23:0];
      req_ch.point_z   <= pz[23:0];
      req_ch.populated <= pop;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_item(f, longint'(signed'(px[23:0])), longint'(signed'(py[23:0])),
                   longint'(signed'(pz[23:0])), pop, fixed_vis);
   endtask

   // drop valid and wait for the next clock edge
   task automatic idle_req();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait until every command, clears included, has left the block
   task automatic drain_all();
      idle_req();
      while (vis_expected.size() != 0) @(posedge clock);
      repeat (fat_tb_pkg::DRAIN_CYC) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input int val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val[23:0];
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         REG_VOXEL_SIZE: p_vs = val[15:0];
         REG_SCAN_X:     p_scan[0] = val[23:0];
         REG_SCAN_Y:     p_scan[1] = val[23:0];
         REG_SCAN_Z:     p_scan[2] = val[23:0];
         REG_ORIGIN_X:   p_org[0] = val[15:0];
         REG_ORIGIN_Y:   p_org[1] = val[15:0];
         REG_ORIGIN_Z:   p_org[2] = val[15:0];
         default: ;
      endcase
   endtask

   // write a full setting; all values in millimetres or voxel indexes
   task automatic set_all(input int vs, input int sx, input int sy, input int sz,
                          input int ox, input int oy, input int oz);
      write_reg(REG_VOXEL_SIZE, vs);
      write_reg(REG_SCAN_X, sx);
      write_reg(REG_SCAN_Y, sy);
      write_reg(REG_SCAN_Z, sz);
      write_reg(REG_ORIGIN_X, ox);
      write_reg(REG_ORIGIN_Y, oy);
      write_reg(REG_ORIGIN_Z, oz);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // coordinate near the grid along one axis, with rare wild values when allowed
   function automatic int grid_coord(input int vs, input int org, input int cells,
                                     input bit allow_wild);
      int r;
      r = $urandom_range(99, 0);
      if (allow_wild && r < 3) return $urandom_range(32'hFFFFFF, 0) - 32'h800000;
      if (allow_wild && r < 8)
         return $urandom_range(8388607, 0) - 8388608 * $urandom_range(1, 0);
      return (org + int'($urandom_range(cells + 1, 0)) - 1) * vs
             + int'($urandom_range(vs - 1, 0));
   endfunction

   // one random phase: mostly marks and queries around the grid
   task automatic random_phase(input int count, input int vs);
      int f, r;
      bit wild;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99, 0);
         if (r < 45) f = FUNC_MARK;
         else if (r < 95) f = FUNC_QUERY;
         else if (r < 97) f = FUNC_CLEAR;
         else f = 3;
         // far query targets only with coarse voxels, to keep walks short
         wild = (f != FUNC_QUERY) || (vs >= 4096);
         send_item(func_type'(f), grid_coord(vs, p_org[0], GX, wild),
                   grid_coord(vs, p_org[1], GY, wild), grid_coord(vs, p_org[2], GZ, wild),
                   ($urandom_range(9, 0) == 0), -1);
      end
   endtask

   // response side: random stalls, in-order compare
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (vis_expected.size() == 0) begin
               report("unexpected visibility", rsp_ch.visibility, -1);
            end else begin
               if (rsp_ch.visibility !== vis_expected[0])
                  report("visibility", rsp_ch.visibility, vis_expected[0]);
               void'(vis_expected.pop_front());
            end
         end
         rsp_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= fat_tb_pkg::IDLE_LIM) begin
         $display("testbench: errors");
         $finish;
      end
   end

   stim_row dir_rows [$];

   initial begin
      int vs;
      req_ch.valid = 1'b0;
      req_ch.func = FUNC_MARK;
      req_ch.point_x = '0;
      req_ch.point_y = '0;
      req_ch.point_z = '0;
      req_ch.populated = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = REG_VOXEL_SIZE;
      csr_ch.data = '0;
      p_vs = 16'd10;
      foreach (p_scan[a]) p_scan[a] = '0;
      foreach (p_org[a]) p_org[a] = '0;
      foreach (occ_map[i]) occ_map[i] = 0;
      repeat (fat_tb_pkg::RST_CYC) @(posedge clock);
      reset <= 1'b0;

      // directed rows under reset settings
      dir_rows = '{
         '{FUNC_QUERY, 0, 0, 0, 1'b0, VIS_VISIBLE},
         '{FUNC_QUERY, 9, 9, 9, 1'b0, VIS_VISIBLE},
         '{FUNC_QUERY, 300, 200, 100, 1'b1, VIS_POPULATED},
         '{FUNC_QUERY, 300, 0, 0, 1'b0, VIS_VISIBLE},
         '{FUNC_MARK, 150, 5, 5, 1'b0, -1},
         '{FUNC_QUERY, 300, 0, 0, 1'b0, VIS_OCCLUDED},
         '{FUNC_MARK, 100, 15, 5, 1'b0, -1},
         '{FUNC_QUERY, 105, 0, 5, 1'b0, -1},
         '{FUNC_QUERY, 200, 200, 200, 1'b0, -1},
         '{FUNC_MARK, 8388607, 8388607, 8388607, 1'b0, -1},
         '{FUNC_MARK, -8388608, -8388608, -8388608, 1'b0, -1},
         '{FUNC_MARK, -5, 0, 0, 1'b0, -1},
         '{FUNC_QUERY, -95, 155, -55, 1'b0, -1},
         '{FUNC_QUERY, 639, -1, 319, 1'b0, -1},
         '{3, 100, 100, 100, 1'b0, -1},
         '{FUNC_CLEAR, 0, 0, 0, 1'b0, -1},
         '{FUNC_QUERY, 300, 0, 0, 1'b0, VIS_VISIBLE},
         '{FUNC_QUERY, -300, -200, -100, 1'b0, VIS_VISIBLE},
         '{FUNC_QUERY, 8388607, 8388607, 8388607, 1'b1, VIS_POPULATED}
      };
      foreach (dir_rows[i])
         send_item(dir_rows[i].func, dir_rows[i].px, dir_rows[i].py, dir_rows[i].pz,
                   dir_rows[i].pop, dir_rows[i].fixed_vis);
      drain_all();

      // settings sweep with idle patterns; each phase about 300 items
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin vs = 10; set_all(10, 325, 315, 155, 0, 0, 0); end
            1: begin vs = 1;  set_all(0, -20, 10, 3, -32, 0, -16); end
            2: begin vs = 65535; set_all(65535, -8388608, 8388607, 0,
                                         -128, 127, 0); end
            3: begin vs = 37; set_all(37, 1200, -900, 400, 0, -40, 0); end
            4: begin vs = 1;  set_all(1, 8388607, -8388608, 100,
                                      32767, -32768, 32767); end
            default: begin vs = 3; set_all(3, 90, 100, 40, 5, 7, 2); end
         endcase
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
         endcase
         // grid setting of phase 4 sits far from scanner; re-center it
         if (ph == 4) set_all(1, 10, -10, 5, 0, -20, 0);
         random_phase(150, vs);
         // hold the sender until the block has answered everything
         idle_req();
         while (vis_expected.size() != 0) @(posedge clock);
         random_phase(150, vs);
         drain_all();
      end

      if (err_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

[filelist.f]
design/fat_pkg.sv
design/fat_if.sv
design/fat_div.sv
design/fat_front.sv
design/fat_back.sv
design/fat_ray_voxel_occlusion_top.sv
dv/fat_tb_if.sv
dv/testbench.sv
